@@ src/sibl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sibl_pkg;

	localparam int MAX_HEADER = 16;
	localparam int SIZE_BITS  = 32;

	localparam int ADDR_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int HC_W    = $clog2(MAX_HEADER + 1);

	localparam logic [ADDR_W-1:0] LOAD_BASE_RESET = 32'h8020_0000;

	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic {
		KIND_SIZE  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic [ADDR_W-1:0] size;
		logic              complete;
	} res_t;

endpackage
`default_nettype wire

@@ src/sibl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface sibl_rx_if;
	logic                       valid;
	logic                       ready;
	logic [sibl_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sibl_res_if;
	logic                       valid;
	logic                       ready;
	logic                       result_kind;
	logic [sibl_pkg::ADDR_W-1:0] write_address;
	logic [sibl_pkg::BYTE_W-1:0] write_data;
	logic [sibl_pkg::ADDR_W-1:0] image_size;
	logic                       image_complete;

	modport source (output valid, output result_kind, output write_address,
		output write_data, output image_size, output image_complete, input ready);
	modport sink   (input valid, input result_kind, input write_address,
		input write_data, input image_size, input image_complete, output ready);
endinterface

interface sibl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sibl_pkg::ADDR_W-1:0] load_base;

	modport source (output valid, output load_base, input ready);
	modport sink   (input valid, input load_base, output ready);
endinterface
`default_nettype wire

@@ src/sibl_len_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// acc * 10 + digit, saturating at the all-ones length
module sibl_len_acc (
	input  wire logic [sibl_pkg::SIZE_BITS-1:0] acc,
	input  wire logic [sibl_pkg::DIGIT_W-1:0]   digit,
	output logic      [sibl_pkg::SIZE_BITS-1:0] sum
);
	import sibl_pkg::*;

	localparam int WIDE_W = SIZE_BITS + 4;

	logic [WIDE_W-1:0] acc_w;
	logic [WIDE_W-1:0] wide;

	assign acc_w = WIDE_W'(acc);
	assign wide  = (acc_w << 3) + (acc_w << 1) + WIDE_W'(digit);
	assign sum   = (wide[WIDE_W-1:SIZE_BITS] != '0) ? '1 : wide[SIZE_BITS-1:0];

endmodule
`default_nettype wire

@@ src/serial_image_boot_loader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake   | payload
// rx      | in  | valid/ready | rx_byte
// res     | out | valid/ready | result_kind, write_address, write_data,
//         |     |             | image_size, image_complete
// cfg     | in  | valid/ready | load_base (always ready)
//
// One item per cycle while rx.ready is high: each byte is decoded in the cycle it is
// accepted and its result, if any, is registered into the output register, or into
// the skid entry while the output register holds a result that is not being taken.
// These two entries form the result buffer; rx.ready drops only while both are full.
// Reset clears the parser to space skipping and load_base to 0x80200000.
module serial_image_boot_loader (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sibl_rx_if.sink    rx,
	sibl_res_if.source res,
	sibl_cfg_if.sink   cfg
);
	import sibl_pkg::*;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_IGNORE,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [HC_W-1:0]      hc_q, hc_d, hc_inc;
	logic [SIZE_BITS-1:0] len_q, len_d, len_sum;
	logic [SIZE_BITS-1:0] rem_q, rem_d, rem_dec;
	logic [ADDR_W-1:0]    addr_q, addr_d;
	logic [ADDR_W-1:0]    base_q;

	res_t                 head_q, skid_q, new_res;
	logic                 head_v_q, skid_v_q;

	logic                 in_fire, pop, push, has_res;
	logic                 is_digit, end_line;
	logic [BYTE_W-1:0]    b;

	assign b        = rx.rx_byte;
	assign rx.ready = !skid_v_q;
	assign cfg.ready = 1'b1;
	assign in_fire  = rx.valid && rx.ready;
	assign pop      = head_v_q && res.ready;
	assign push     = in_fire && has_res;

	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign hc_inc   = hc_q + 1'b1;
	assign rem_dec  = rem_q - 1'b1;

	sibl_len_acc u_len_acc (
		.acc   (len_q),
		.digit (b[DIGIT_W-1:0]),
		.sum   (len_sum)
	);

	always_comb begin
		phase_d  = phase_q;
		hc_d     = hc_q;
		len_d    = len_q;
		rem_d    = rem_q;
		addr_d   = addr_q;
		has_res  = 1'b0;
		end_line = 1'b0;
		new_res  = '{kind: KIND_SIZE, addr: '0, data: '0, size: '0, complete: 1'b0};
		case (phase_q)
			PH_DONE: begin
			end
			PH_PAYLOAD: begin
				rem_d   = rem_dec;
				addr_d  = addr_q + 1'b1;
				if (rem_dec == '0) begin
					phase_d = PH_DONE;
				end
				has_res = 1'b1;
				new_res = '{kind: KIND_WRITE, addr: addr_q, data: b,
					size: ADDR_W'(len_q), complete: (rem_dec == '0)};
			end
			default: begin
				hc_d = hc_inc;
				if (b == CH_LF) begin
					end_line = 1'b1;
				end else begin
					if (phase_q == PH_SKIP) begin
						if (is_digit) begin
							len_d   = len_sum;
							phase_d = PH_DIGITS;
						end else if (b != CH_SPACE) begin
							phase_d = PH_IGNORE;
						end
					end else if (phase_q == PH_DIGITS) begin
						if (is_digit) begin
							len_d = len_sum;
						end else begin
							phase_d = PH_IGNORE;
						end
					end
					end_line = (hc_inc >= HC_W'(MAX_HEADER));
				end
				if (end_line) begin
					addr_d  = base_q;
					rem_d   = len_d;
					phase_d = (len_d == '0) ? PH_DONE : PH_PAYLOAD;
					has_res = 1'b1;
					new_res = '{kind: KIND_SIZE, addr: base_q, data: '0,
						size: ADDR_W'(len_d), complete: (len_d == '0)};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			hc_q     <= '0;
			len_q    <= '0;
			rem_q    <= '0;
			addr_q   <= '0;
			base_q   <= LOAD_BASE_RESET;
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.load_base;
			end
			if (in_fire) begin
				phase_q <= phase_d;
				hc_q    <= hc_d;
				len_q   <= len_d;
				rem_q   <= rem_d;
				addr_q  <= addr_d;
			end
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else if (!push) begin
					head_v_q <= 1'b0;
				end
			end else if (push) begin
				if (head_v_q) begin
					skid_v_q <= 1'b1;
				end else begin
					head_v_q <= 1'b1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= new_res;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= new_res;
			end else begin
				head_q <= new_res;
			end
		end
	end

	assign res.valid          = head_v_q;
	assign res.result_kind    = head_q.kind;
	assign res.write_address  = head_q.addr;
	assign res.write_data     = head_q.data;
	assign res.image_size     = head_q.size;
	assign res.image_complete = head_q.complete;

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> head_v_q)
		else $error("skid entry held without output entry");

	a_last_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_PAYLOAD && rem_q == SIZE_BITS'(1))
		|=> (phase_q == PH_DONE))
		else $error("last payload byte did not finish the image");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("payload phase with nothing left to write");

	a_header_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP || phase_q == PH_DIGITS || phase_q == PH_IGNORE)
		|-> (hc_q < HC_W'(MAX_HEADER)))
		else $error("header count passed its bound");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_DONE) |-> !push)
		else $error("result produced after image completion");

endmodule
`default_nettype wire
